// ===== rtl/tsra_pkg.sv =====
// Shared types, constants and helpers for the temperature sample ring.
package tsra_pkg;

    // Ring geometry
    localparam int RING_DEPTH = 64;
    localparam int PTR_W      = $clog2(RING_DEPTH);

    // Field widths
    localparam int FUNC_W = 2;
    localparam int TEMP_W = 19;
    localparam int TIME_W = 64;
    localparam int CNT_W  = 32;

    // Stored entry: timestamp low, temperature above it, alert flag on top
    localparam int ENTRY_W = TIME_W + TEMP_W + 1;

    // Stream payload widths
    localparam int S_FIELDS_W = TEMP_W + TIME_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = TEMP_W + TIME_W + 1 + 2 * CNT_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    // Alert threshold after reset, in milli-Celsius
    localparam logic signed [TEMP_W-1:0] THRESH_RESET = TEMP_W'(42000);

    // Item functions
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH = 2'd0,
        FUNC_POP  = 2'd1,
        FUNC_CLR  = 2'd2,
        FUNC_READ = 2'd3
    } func_t;

    // Controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // capture the input transfer and read the oldest entry
        logic exec;   // update ring state and load the result register
    } cmd_t;

    // Advance a ring pointer with wrap
    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(RING_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/temp_sample_ring_with_alert_top.sv =====
// Top level of the temperature sample ring with threshold alert.
//
// Each input transfer carries a function in s_tuser: push a sample (temperature
// and timestamp), pop the oldest sample, clear the update/alert counters, or
// read them. Pushes mark a sample as alert when its temperature is at or above
// the signed threshold written through cfg_we/cfg_wdata (42000 mC after reset);
// a push into a full ring drops the oldest sample, so the ring holds up to
// RING_DEPTH-1 samples. Every item gives exactly one result transfer; m_tuser
// flags a pop that found the ring empty, and data_ready reports whether samples
// remain. An item is captured in ST_IDLE while the ring memory's registered
// read fetches the oldest entry; ST_EXEC then updates pointers, counters and
// the ring and loads the output register. A new item can be taken while the
// previous result is being transferred out, but not while one is in ST_EXEC.
// Ring contents need no clearing after reset; the block is ready as soon as
// aresetn is released.
module temp_sample_ring_with_alert_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Threshold register write
    input  logic                               cfg_we,
    input  logic [tsra_pkg::TEMP_W-1:0]        cfg_wdata,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tsra_pkg::S_TDATA_W-1:0]     s_tdata,  // temp_mc, timestamp
    input  logic [tsra_pkg::FUNC_W-1:0]        s_tuser,  // func
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_temp, out_time, out_alert, updates, alerts, data_ready
    output logic [tsra_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [0:0]                         m_tuser   // status
);

    localparam int TW = tsra_pkg::TEMP_W;
    localparam int MW = tsra_pkg::TIME_W;

    tsra_pkg::cmd_t cmd;
    logic           status;

    tsra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tsra_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_func    (s_tuser),
        .in_temp    (s_tdata[TW-1:0]),
        .in_time    (s_tdata[TW+MW-1:TW]),
        .out_status (status),
        .out_data   (m_tdata)
    );

    assign m_tuser = status;

`ifndef SYNTHESIS
    // Accepted item has its result presented once ST_EXEC has loaded it
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> ##2 m_tvalid)
        else $error("result not presented two cycles after input transfer");

    // No new item is taken while one is being executed
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted during execution");

    // An empty pop carries no sample and leaves the ring empty
    a_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[TW+MW:0] == '0) && !m_tdata[tsra_pkg::M_FIELDS_W-1])
        else $error("empty pop result carries data");
`endif

endmodule

// ===== rtl/tsra_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tsra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tsra_ctrl.sv =====
// Controller: input/output handshake and sequencing of one item at a time.
module tsra_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output tsra_pkg::cmd_t cmd
);

    tsra_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;

    // State and result-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tsra_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        s_tready       = 1'b0;
        accept         = 1'b0;
        cmd            = '0;

        // Drop the result once the transfer completes
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            tsra_pkg::ST_IDLE: begin
                s_tready = !out_valid_reg || m_tready;
                accept   = s_tready && s_tvalid;
                if (accept) begin
                    cmd.load   = 1'b1;
                    state_next = tsra_pkg::ST_EXEC;
                end
            end
            tsra_pkg::ST_EXEC: begin
                cmd.exec       = 1'b1;
                out_valid_next = 1'b1;
                state_next     = tsra_pkg::ST_IDLE;
            end
            default: begin
                state_next = tsra_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== rtl/tsra_dp.sv =====
// Datapath: threshold register, ring pointers, counters, ring memory, result register.
module tsra_dp (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  tsra_pkg::cmd_t                         cmd,
    input  logic                                   cfg_we,
    input  logic signed [tsra_pkg::TEMP_W-1:0]     cfg_wdata,
    input  logic [tsra_pkg::FUNC_W-1:0]            in_func,
    input  logic signed [tsra_pkg::TEMP_W-1:0]     in_temp,
    input  logic [tsra_pkg::TIME_W-1:0]            in_time,
    output logic                                   out_status,
    output logic [tsra_pkg::M_TDATA_W-1:0]         out_data
);

    localparam int PW = tsra_pkg::PTR_W;
    localparam int TW = tsra_pkg::TEMP_W;
    localparam int MW = tsra_pkg::TIME_W;
    localparam int CW = tsra_pkg::CNT_W;
    localparam int EW = tsra_pkg::ENTRY_W;

    // Control state
    logic signed [TW-1:0] thresh_reg;
    logic [PW-1:0]        wptr_reg, wptr_next;
    logic [PW-1:0]        rptr_reg, rptr_next;
    logic [CW-1:0]        upd_cnt_reg, upd_cnt_next;
    logic [CW-1:0]        alr_cnt_reg, alr_cnt_next;

    // Captured item
    tsra_pkg::func_t      func_reg;
    logic signed [TW-1:0] temp_reg;
    logic [MW-1:0]        time_reg;

    // Result register
    logic                 status_reg, status_next;
    logic signed [TW-1:0] otemp_reg, otemp_next;
    logic [MW-1:0]        otime_reg, otime_next;
    logic                 oalert_reg, oalert_next;
    logic [CW-1:0]        oupd_reg, oupd_next;
    logic [CW-1:0]        oalr_reg, oalr_next;
    logic                 ready_reg, ready_next;

    // Ring memory signals
    logic          ram_we;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] ram_rdata;
    logic          alert;
    logic          empty;
    logic [PW-1:0] wptr_inc;

    tsra_ram #(
        .WIDTH (EW),
        .DEPTH (tsra_pkg::RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wptr_reg),
        .wr_data (ram_wdata),
        .rd_en   (cmd.load),
        .rd_addr (rptr_reg),
        .rd_data (ram_rdata)
    );

    // Threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= tsra_pkg::THRESH_RESET;
        end else if (cfg_we) begin
            thresh_reg <= cfg_wdata;
        end
    end

    // Capture the accepted item
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= tsra_pkg::func_t'(in_func);
            temp_reg <= in_temp;
            time_reg <= in_time;
        end
    end

    // Pointers and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg    <= '0;
            rptr_reg    <= '0;
            upd_cnt_reg <= '0;
            alr_cnt_reg <= '0;
        end else begin
            wptr_reg    <= wptr_next;
            rptr_reg    <= rptr_next;
            upd_cnt_reg <= upd_cnt_next;
            alr_cnt_reg <= alr_cnt_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg <= status_next;
            otemp_reg  <= otemp_next;
            otime_reg  <= otime_next;
            oalert_reg <= oalert_next;
            oupd_reg   <= oupd_next;
            oalr_reg   <= oalr_next;
            ready_reg  <= ready_next;
        end
    end

    assign alert     = temp_reg >= thresh_reg;
    assign empty     = wptr_reg == rptr_reg;
    assign wptr_inc  = tsra_pkg::ptr_next(wptr_reg);
    assign ram_wdata = {alert, temp_reg, time_reg};

    // Execute one item
    always_comb begin
        wptr_next    = wptr_reg;
        rptr_next    = rptr_reg;
        upd_cnt_next = upd_cnt_reg;
        alr_cnt_next = alr_cnt_reg;
        ram_we       = 1'b0;
        status_next  = 1'b0;
        otemp_next   = '0;
        otime_next   = '0;
        oalert_next  = 1'b0;
        oupd_next    = '0;
        oalr_next    = '0;

        if (cmd.exec) begin
            unique case (func_reg)
                tsra_pkg::FUNC_PUSH: begin
                    ram_we       = 1'b1;
                    upd_cnt_next = upd_cnt_reg + 1'b1;
                    if (alert) begin
                        alr_cnt_next = alr_cnt_reg + 1'b1;
                    end
                    wptr_next = wptr_inc;
                    // Full ring: drop the oldest entry
                    if (wptr_inc == rptr_reg) begin
                        rptr_next = tsra_pkg::ptr_next(rptr_reg);
                    end
                end
                tsra_pkg::FUNC_POP: begin
                    if (empty) begin
                        status_next = 1'b1;
                    end else begin
                        otime_next  = ram_rdata[MW-1:0];
                        otemp_next  = ram_rdata[MW+TW-1:MW];
                        oalert_next = ram_rdata[EW-1];
                        rptr_next   = tsra_pkg::ptr_next(rptr_reg);
                    end
                end
                tsra_pkg::FUNC_CLR: begin
                    upd_cnt_next = '0;
                    alr_cnt_next = '0;
                end
                tsra_pkg::FUNC_READ: begin
                    oupd_next = upd_cnt_reg;
                    oalr_next = alr_cnt_reg;
                end
                default: begin
                    status_next = 1'b0;
                end
            endcase
        end

        ready_next = wptr_next != rptr_next;
    end

    // Pack the result, first field in the lowest bits
    assign out_status = status_reg;
    assign out_data   = {{tsra_pkg::M_PAD_W{1'b0}}, ready_reg, oalr_reg, oupd_reg,
                         oalert_reg, otime_reg, otemp_reg};

endmodule

// ===== dv/tsra_ring_checker.sv =====
// Checker for the temperature sample ring: predicts each result and compares it on the result stream.
module tsra_ring_checker
    import tsra_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [TEMP_W-1:0]      cfg_wdata,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic [FUNC_W-1:0]      s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [M_TDATA_W-1:0]   m_tdata,
    input  logic [0:0]             m_tuser,
    output int                     fail_count,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Result fields as the block reports them
    typedef struct packed {
        logic                     status;
        logic signed [TEMP_W-1:0] temp;
        logic [TIME_W-1:0]        stamp;
        logic                     alert;
        logic [CNT_W-1:0]         updates;
        logic [CNT_W-1:0]         alerts;
        logic                     data_ready;
    } ring_result_t;

    // Offsets of the result fields in m_tdata
    localparam int OFS_TIME   = TEMP_W;
    localparam int OFS_ALERT  = OFS_TIME + TIME_W;
    localparam int OFS_UPD    = OFS_ALERT + 1;
    localparam int OFS_ALR    = OFS_UPD + CNT_W;
    localparam int OFS_READY  = OFS_ALR + CNT_W;

    // Shadow of the ring, its pointers, counters and threshold
    logic [TIME_W-1:0]        shadow_stamp [RING_DEPTH];
    logic signed [TEMP_W-1:0] shadow_temp  [RING_DEPTH];
    logic                     shadow_hot   [RING_DEPTH];
    logic [PTR_W-1:0]         wr_ptr;
    logic [PTR_W-1:0]         rd_ptr;
    logic [CNT_W-1:0]         update_cnt;
    logic [CNT_W-1:0]         alert_cnt;
    logic signed [TEMP_W-1:0] threshold;

    ring_result_t results_due [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p);
        return PTR_W'((int'(p) + 1) % RING_DEPTH);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [TIME_W-1:0] got,
                               input logic [TIME_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
        end
    endtask

    // Apply one input transfer to the shadow state and queue its result
    task automatic apply_ring_op(input func_t op, input logic signed [TEMP_W-1:0] t,
                                 input logic [TIME_W-1:0] stamp);
        ring_result_t r;
        logic hot;
        r = '0;
        case (op)
            FUNC_PUSH: begin
                hot = (t >= threshold);
                update_cnt++;
                if (hot) begin
                    alert_cnt++;
                end
                shadow_stamp[wr_ptr] = stamp;
                shadow_temp[wr_ptr]  = t;
                shadow_hot[wr_ptr]   = hot;
                wr_ptr = step_ptr(wr_ptr);
                // full ring: drop the oldest sample
                if (wr_ptr == rd_ptr) begin
                    rd_ptr = step_ptr(rd_ptr);
                end
            end
            FUNC_POP: begin
                if (wr_ptr == rd_ptr) begin
                    r.status = 1'b1;
                end else begin
                    r.temp  = shadow_temp[rd_ptr];
                    r.stamp = shadow_stamp[rd_ptr];
                    r.alert = shadow_hot[rd_ptr];
                    rd_ptr  = step_ptr(rd_ptr);
                end
            end
            FUNC_CLR: begin
                update_cnt = '0;
                alert_cnt  = '0;
            end
            default: begin
                r.updates = update_cnt;
                r.alerts  = alert_cnt;
            end
        endcase
        r.data_ready = (wr_ptr != rd_ptr);
        results_due.push_back(r);
    endtask

    // Compare one result transfer with the oldest expectation
    task automatic check_result();
        ring_result_t want;
        if (results_due.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected, tdata %h", m_tdata));
        end else begin
            want = results_due.pop_front();
            check_field("status", TIME_W'(m_tuser[0]), TIME_W'(want.status));
            check_field("out_temp", TIME_W'(m_tdata[TEMP_W-1:0]),
                        TIME_W'(want.temp[TEMP_W-1:0]));
            check_field("out_time", m_tdata[OFS_TIME +: TIME_W], want.stamp);
            check_field("out_alert", TIME_W'(m_tdata[OFS_ALERT]), TIME_W'(want.alert));
            check_field("updates", TIME_W'(m_tdata[OFS_UPD +: CNT_W]), TIME_W'(want.updates));
            check_field("alerts", TIME_W'(m_tdata[OFS_ALR +: CNT_W]), TIME_W'(want.alerts));
            check_field("data_ready", TIME_W'(m_tdata[OFS_READY]), TIME_W'(want.data_ready));
        end
    endtask

    // Track the channels at each rising edge; results first, they belong to older items
    always @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr     = '0;
            rd_ptr     = '0;
            update_cnt = '0;
            alert_cnt  = '0;
            threshold  = THRESH_RESET;
            results_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
            end
            if (cfg_we) begin
                threshold = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                apply_ring_op(func_t'(s_tuser), s_tdata[TEMP_W-1:0],
                              s_tdata[TEMP_W +: TIME_W]);
            end
        end
        pending = results_due.size();
    end

endmodule

// ===== dv/temp_sample_ring_with_alert_top_tb.sv =====
// Testbench top for the temperature sample ring: stimulus, flow control and verdict.
module temp_sample_ring_with_alert_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsra_pkg::*;

    localparam int HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT = 3000;
    localparam int PAD_W       = S_TDATA_W - TEMP_W - TIME_W;
    localparam int NUM_PHASES  = 7;

    typedef enum {MIX_OPS, PUSH_HEAVY, POP_HEAVY} op_mix_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [TEMP_W-1:0]     cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [FUNC_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [0:0]            m_tuser;
    int                    fail_count;
    int                    pending;

    // Stimulus flags shared with the sink process, and the watchdog's idle counter
    bit no_idle;
    bit hold_req;
    int quiet;

    temp_sample_ring_with_alert_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    tsra_ring_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Drive every input to a known value from time zero
    initial begin
        aclk      = 1'b0;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = FUNC_PUSH;
        m_tready  = 1'b0;
        no_idle   = 1'b0;
        hold_req  = 1'b0;
        quiet     = 0;
    end

    always #6 aclk = ~aclk;

    // Mostly short pauses, a few long ones
    function automatic int pick_stall();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) begin
            return 0;
        end
        return pick_stall();
    endfunction

    function automatic func_t pick_func(input op_mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            PUSH_HEAVY: return (r < 70) ? FUNC_PUSH : (r < 90) ? FUNC_POP :
                               (r < 93) ? FUNC_CLR : FUNC_READ;
            POP_HEAVY:  return (r < 25) ? FUNC_PUSH : (r < 85) ? FUNC_POP :
                               (r < 90) ? FUNC_CLR : FUNC_READ;
            default:    return (r < 45) ? FUNC_PUSH : (r < 80) ? FUNC_POP :
                               (r < 88) ? FUNC_CLR : FUNC_READ;
        endcase
    endfunction

    // Cluster temperatures around the threshold, with extremes and full-range noise
    function automatic logic signed [TEMP_W-1:0] pick_temp(input logic signed [TEMP_W-1:0] thr);
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            return thr + TEMP_W'($urandom_range(0, 4)) - TEMP_W'(2);
        end else if (r < 45) begin
            return ($urandom_range(0, 1) != 0) ? {1'b0, {(TEMP_W-1){1'b1}}}
                                               : {1'b1, {(TEMP_W-1){1'b0}}};
        end
        return TEMP_W'($urandom);
    endfunction

    // Offer one item from a falling edge; return at the falling edge after its transfer
    task automatic send_item(input func_t op, input logic signed [TEMP_W-1:0] t,
                             input logic [TIME_W-1:0] stamp);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{PAD_W{1'b0}}, stamp, t};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_random(input func_t op, input logic signed [TEMP_W-1:0] thr);
        send_item(op, pick_temp(thr), {$urandom, $urandom});
    endtask

    // Stop offering, let every result drain, then write the threshold
    task automatic write_threshold(input logic signed [TEMP_W-1:0] value);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Result sink: random stalls, open stretches and one long hold-off
    initial begin : sink_ctrl
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_req = 1'b0;
            end else if (no_idle) begin
                m_tready <= 1'b1;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < 30) begin
                    stall = pick_stall();
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        logic signed [TEMP_W-1:0] thr_list [NUM_PHASES];
        op_mix_t                  mix_list [NUM_PHASES];
        int                       len_list [NUM_PHASES];
        logic signed [TEMP_W-1:0] thr;

        thr_list = '{THRESH_RESET, -TEMP_W'(262144), TEMP_W'(262143), '0,
                     TEMP_W'($urandom), -TEMP_W'(1), TEMP_W'($urandom_range(0, 90000))};
        mix_list = '{MIX_OPS, PUSH_HEAVY, PUSH_HEAVY, POP_HEAVY, MIX_OPS, PUSH_HEAVY, POP_HEAVY};
        len_list = '{50, 80, 60, 80, 60, 60, 60};

        // Hold reset, then release it on a falling edge
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty pop, threshold edge, field extremes, counter clear and read
        send_item(FUNC_POP,  '0, '0);
        send_item(FUNC_READ, '0, '0);
        send_item(FUNC_PUSH, TEMP_W'(42000), '0);
        send_item(FUNC_PUSH, TEMP_W'(41999), {TIME_W{1'b1}});
        send_item(FUNC_PUSH, TEMP_W'(262143), {16{4'hA}});
        send_item(FUNC_PUSH, -TEMP_W'(262144), {16{4'h5}});
        send_item(FUNC_PUSH, '0, TIME_W'(1));
        send_item(FUNC_READ, '0, '0);
        send_item(FUNC_POP,  '0, '0);
        send_item(FUNC_POP,  '0, '0);
        send_item(FUNC_CLR,  '0, '0);
        send_item(FUNC_READ, '0, '0);
        repeat (4) send_item(FUNC_POP, '0, '0);
        send_item(FUNC_PUSH, -TEMP_W'(1), {1'b1, {(TIME_W-1){1'b0}}});
        send_item(FUNC_READ, '0, '0);
        send_item(FUNC_POP,  '0, '0);

        // Random phases, each under its own threshold
        for (int p = 0; p < NUM_PHASES; p++) begin
            thr = thr_list[p];
            if (p > 0) begin
                write_threshold(thr);
            end
            no_idle = (p == 0);
            // fill the block against a stalled sink
            if (p == 2) begin
                hold_req = 1'b1;
            end
            for (int i = 0; i < len_list[p]; i++) begin
                send_random(pick_func(mix_list[p]), thr);
            end
        end

        // Drain and give the verdict
        no_idle = 1'b0;
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
